// ===== rtl/oked_pkg.sv =====
package oked_pkg;

   // Default build values
   localparam int GRID_POINTS_DEF = 4096;
   localparam int FRAC_BITS_DEF   = 12;

   // Field widths
   localparam int POINT_W = 12;
   localparam int VAL_W   = 16;
   localparam int PROD_W  = 2 * VAL_W;
   localparam int GRAD_W  = 40;
   localparam int DENS_W  = 48;

   // Stream payload widths, fields packed from bit 0 up, padded to bytes
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 64;

   // Square accumulator: three squared 40-bit magnitudes, doubled, fit in 82 bits
   localparam int HALF_W = GRAD_W / 2;
   localparam int ACC_W  = 82;

endpackage

// ===== rtl/orbital_kinetic_energy_density.sv =====
// Orbital kinetic energy density accumulator.
//
// req_* carries one basis function per beat: grid point, spin, orbital
// coefficient and the x/y/z basis derivatives, with req_tlast closing the
// orbital and req_tuser flagging the first orbital (overwrite instead of add).
// rsp_* returns one beat per orbital: the point, spin and updated density.
// csr_* writes restricted_mode (1 doubles each orbital contribution).
//
// Throughput: beats without tlast are taken one per cycle while the block is
// idle; the gradient sums absorb them through a registered product stage. A
// tlast beat occupies the block until write-back completes: the squared
// gradient is built on one shared 20x20 multiplier over nine passes, then the
// density entry goes through a read-modify-write of the density store. The
// result beat is registered when write-back completes.
//
// Reset clears the gradient sums, sets restricted_mode to 1 and drops any
// pending result; the density store is not cleared and each entry must be
// written by a first-orbital beat before it is accumulated into.
// A waiting result sits in the output register; while it is not taken,
// beats are still accepted and only the next tlast beat holds at write-back.
module orbital_kinetic_energy_density #(
   parameter int GRID_POINTS = oked_pkg::GRID_POINTS_DEF,
   parameter int FRAC_BITS   = oked_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // point_index[11:0], spin[12], coeff[28:13], deriv_x[44:29],
   // deriv_y[60:45], deriv_z[76:61], zero pad[79:77]
   input  logic [oked_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tlast,    // last_basis
   input  logic                            req_tuser,    // first_orbital
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // point_out[11:0], spin_out[12], density[60:13], zero pad[63:61]
   output logic [oked_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_data      // restricted_mode
);

   localparam int POINT_W     = oked_pkg::POINT_W;
   localparam int VAL_W       = oked_pkg::VAL_W;
   localparam int PROD_W      = oked_pkg::PROD_W;
   localparam int GRAD_W      = oked_pkg::GRAD_W;
   localparam int DENS_W      = oked_pkg::DENS_W;
   localparam int HALF_W      = oked_pkg::HALF_W;
   localparam int ACC_W       = oked_pkg::ACC_W;
   localparam int SQ_W        = 2 * HALF_W;
   localparam int SHIFT       = 2 * FRAC_BITS;
   localparam int STORE_DEPTH = 2 * GRID_POINTS;
   localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int SUM_W       = ((AW > POINT_W) ? AW : POINT_W) + 1;
   localparam int GP_W        = $clog2(GRID_POINTS + 1) + 1;
   localparam int QG_W        = POINT_W + GP_W;
   // point reduction: q = floor(p / GRID_POINTS) = (p * RECIP) >> RECIP_SH,
   // exact for every 12-bit p
   localparam int RECIP_SH    = 2 * POINT_W;
   localparam int RECIP_W     = RECIP_SH + 1;
   localparam int QP_W        = POINT_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((1 << RECIP_SH) + GRID_POINTS - 1) / GRID_POINTS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_GRAD  = 3'd1;
   localparam logic [2:0] S_SQ    = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_SHIFT = 3'd4;
   localparam logic [2:0] S_WRITE = 3'd5;

   localparam logic [1:0] PART_HH = 2'd0;
   localparam logic [1:0] PART_HL = 2'd1;
   localparam logic [1:0] PART_LL = 2'd2;

   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

   localparam logic signed [GRAD_W:0] GRAD_MAX = {2'b00, {(GRAD_W-1){1'b1}}};
   localparam logic signed [GRAD_W:0] GRAD_MIN = {2'b11, {(GRAD_W-1){1'b0}}};

   // control registers
   logic [2:0]              state_ff, state_in;
   logic [1:0]              comp_ff, comp_in;
   logic [1:0]              part_ff, part_in;
   logic                    prod_valid_ff, prod_valid_in;
   logic                    mul_valid_ff, mul_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    restricted_ff, restricted_in;
   logic signed [GRAD_W-1:0] grad_x_ff, grad_x_in;
   logic signed [GRAD_W-1:0] grad_y_ff, grad_y_in;
   logic signed [GRAD_W-1:0] grad_z_ff, grad_z_in;

   // payload registers
   logic signed [PROD_W-1:0] prod_x_ff, prod_x_in;
   logic signed [PROD_W-1:0] prod_y_ff, prod_y_in;
   logic signed [PROD_W-1:0] prod_z_ff, prod_z_in;
   logic [POINT_W-1:0]      pt_ff, pt_in;
   logic                    spin_ff, spin_in;
   logic                    first_ff, first_in;
   logic [POINT_W-1:0]      q_ff, q_in;
   logic [POINT_W-1:0]      r_ff, r_in;
   logic [AW-1:0]           addr_ff, addr_in;
   logic [SQ_W-1:0]         mul_ff, mul_in;
   logic [1:0]              mul_part_ff, mul_part_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [DENS_W-1:0]       contrib_ff, contrib_in;
   logic [DENS_W-1:0]       rd_ff;
   logic [POINT_W-1:0]      rsp_point_ff, rsp_point_in;
   logic                    rsp_spin_ff, rsp_spin_in;
   logic [DENS_W-1:0]       rsp_dens_ff, rsp_dens_in;

   // density store
   logic [DENS_W-1:0]       store_mem [STORE_DEPTH];
   logic                    wr_en;
   logic [DENS_W-1:0]       wr_data;

   // combinational helpers
   logic                    req_fire;
   logic                    out_free;
   logic signed [VAL_W-1:0] coeff, deriv_x, deriv_y, deriv_z;
   logic signed [GRAD_W-1:0] grad_sel;
   logic [GRAD_W-1:0]       mag;
   logic [HALF_W-1:0]       mag_hi, mag_lo;
   logic [QP_W-1:0]         q_prod;
   logic [QG_W-1:0]         qg_prod;
   logic [SUM_W-1:0]        addr_sum;
   logic [ACC_W-1:0]        acc_term;
   logic [ACC_W-1:0]        acc_dbl;
   logic [ACC_W-1:0]        acc_shr;
   logic [DENS_W:0]         dens_sum;
   logic [DENS_W-1:0]       dens_old;

   // saturating add of one product into a gradient sum
   function automatic logic signed [GRAD_W-1:0] grad_add(
      input logic signed [GRAD_W-1:0] g,
      input logic signed [PROD_W-1:0] p
   );
      logic signed [GRAD_W:0] s;
      s = (GRAD_W+1)'(g) + (GRAD_W+1)'(p);
      if (s > GRAD_MAX) begin
         return GRAD_MAX[GRAD_W-1:0];
      end else if (s < GRAD_MIN) begin
         return GRAD_MIN[GRAD_W-1:0];
      end
      return s[GRAD_W-1:0];
   endfunction

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign coeff   = req_tdata[28:13];
   assign deriv_x = req_tdata[44:29];
   assign deriv_y = req_tdata[60:45];
   assign deriv_z = req_tdata[76:61];

   // pick the gradient component for the current square pass
   always_comb begin
      unique case (comp_ff)
         COMP_X:  grad_sel = grad_x_ff;
         COMP_Y:  grad_sel = grad_y_ff;
         COMP_Z:  grad_sel = grad_z_ff;
         default: grad_sel = '0;
      endcase
   end

   assign mag    = grad_sel[GRAD_W-1] ? GRAD_W'(-grad_sel) : GRAD_W'(grad_sel);
   assign mag_hi = mag[GRAD_W-1:HALF_W];
   assign mag_lo = mag[HALF_W-1:0];

   assign q_prod   = QP_W'(pt_ff) * QP_W'(RECIP);
   assign qg_prod  = QG_W'(q_ff) * QG_W'(GRID_POINTS);
   assign addr_sum = SUM_W'(r_ff) + (spin_ff ? SUM_W'(GRID_POINTS) : SUM_W'(0));

   // weight the registered partial product: hi*hi at 2H, 2*hi*lo at H, lo*lo at 0
   always_comb begin
      unique case (mul_part_ff)
         PART_HH: acc_term = ACC_W'(mul_ff) << (2 * HALF_W);
         PART_HL: acc_term = ACC_W'(mul_ff) << (HALF_W + 1);
         PART_LL: acc_term = ACC_W'(mul_ff);
         default: acc_term = '0;
      endcase
   end

   assign acc_dbl  = restricted_ff ? (acc_ff << 1) : acc_ff;
   assign acc_shr  = acc_dbl >> SHIFT;
   assign dens_old = first_ff ? '0 : rd_ff;
   assign dens_sum = (DENS_W+1)'(dens_old) + (DENS_W+1)'(contrib_ff);
   assign wr_data  = dens_sum[DENS_W] ? {DENS_W{1'b1}} : dens_sum[DENS_W-1:0];
   assign wr_en    = (state_ff == S_WRITE) && out_free;

   // next-state and datapath
   always_comb begin
      state_in      = state_ff;
      comp_in       = comp_ff;
      part_in       = part_ff;
      prod_valid_in = req_fire;
      mul_valid_in  = (state_ff == S_SQ);
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      restricted_in = csr_valid ? csr_data : restricted_ff;
      grad_x_in     = grad_x_ff;
      grad_y_in     = grad_y_ff;
      grad_z_in     = grad_z_ff;

      prod_x_in     = prod_x_ff;
      prod_y_in     = prod_y_ff;
      prod_z_in     = prod_z_ff;
      pt_in         = pt_ff;
      spin_in       = spin_ff;
      first_in      = first_ff;
      q_in          = q_ff;
      r_in          = r_ff;
      addr_in       = addr_ff;
      mul_in        = SQ_W'(0);
      mul_part_in   = part_ff;
      acc_in        = acc_ff;
      contrib_in    = contrib_ff;
      rsp_point_in  = rsp_point_ff;
      rsp_spin_in   = rsp_spin_ff;
      rsp_dens_in   = rsp_dens_ff;

      // capture the beat and its three products
      if (req_fire) begin
         prod_x_in = PROD_W'(coeff * deriv_x);
         prod_y_in = PROD_W'(coeff * deriv_y);
         prod_z_in = PROD_W'(coeff * deriv_z);
         pt_in     = req_tdata[POINT_W-1:0];
         spin_in   = req_tdata[POINT_W];
         first_in  = req_tuser;
      end

      // fold the registered products into the gradient sums
      if (prod_valid_ff) begin
         grad_x_in = grad_add(grad_x_ff, prod_x_ff);
         grad_y_in = grad_add(grad_y_ff, prod_y_ff);
         grad_z_in = grad_add(grad_z_ff, prod_z_ff);
      end

      // accumulate weighted partial products
      if (mul_valid_ff) begin
         acc_in = acc_ff + acc_term;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_tlast) begin
               state_in = S_GRAD;
            end
         end
         S_GRAD: begin
            q_in     = q_prod[RECIP_SH +: POINT_W];
            acc_in   = '0;
            comp_in  = COMP_X;
            part_in  = PART_HH;
            state_in = S_SQ;
         end
         S_SQ: begin
            r_in    = pt_ff - qg_prod[POINT_W-1:0];
            addr_in = addr_sum[AW-1:0];
            unique case (part_ff)
               PART_HH: mul_in = SQ_W'(mag_hi) * SQ_W'(mag_hi);
               PART_HL: mul_in = SQ_W'(mag_hi) * SQ_W'(mag_lo);
               PART_LL: mul_in = SQ_W'(mag_lo) * SQ_W'(mag_lo);
               default: mul_in = SQ_W'(0);
            endcase
            if (part_ff == PART_LL) begin
               part_in = PART_HH;
               if (comp_ff == COMP_Z) begin
                  state_in = S_DRAIN;
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end else begin
               part_in = part_ff + 2'd1;
            end
         end
         S_DRAIN: begin
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            contrib_in = (|acc_shr[ACC_W-1:DENS_W]) ? {DENS_W{1'b1}} : acc_shr[DENS_W-1:0];
            grad_x_in  = '0;
            grad_y_in  = '0;
            grad_z_in  = '0;
            state_in   = S_WRITE;
         end
         S_WRITE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_point_in = r_ff;
               rsp_spin_in  = spin_ff;
               rsp_dens_in  = wr_data;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         comp_ff       <= COMP_X;
         part_ff       <= PART_HH;
         prod_valid_ff <= 1'b0;
         mul_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         restricted_ff <= 1'b1;
         grad_x_ff     <= '0;
         grad_y_ff     <= '0;
         grad_z_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         comp_ff       <= comp_in;
         part_ff       <= part_in;
         prod_valid_ff <= prod_valid_in;
         mul_valid_ff  <= mul_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         restricted_ff <= restricted_in;
         grad_x_ff     <= grad_x_in;
         grad_y_ff     <= grad_y_in;
         grad_z_ff     <= grad_z_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      prod_x_ff    <= prod_x_in;
      prod_y_ff    <= prod_y_in;
      prod_z_ff    <= prod_z_in;
      pt_ff        <= pt_in;
      spin_ff      <= spin_in;
      first_ff     <= first_in;
      q_ff         <= q_in;
      r_ff         <= r_in;
      addr_ff      <= addr_in;
      mul_ff       <= mul_in;
      mul_part_ff  <= mul_part_in;
      acc_ff       <= acc_in;
      contrib_ff   <= contrib_in;
      rsp_point_ff <= rsp_point_in;
      rsp_spin_ff  <= rsp_spin_in;
      rsp_dens_ff  <= rsp_dens_in;
   end

   // density store: one synchronous read and one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[addr_ff] <= wr_data;
      end
      rd_ff <= store_mem[addr_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_dens_ff, rsp_spin_ff, rsp_point_ff};

   // a tlast beat always starts the finishing sequence
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> (state_ff == S_GRAD))
      else $error("tlast beat did not start the finishing sequence");

   // gradient sums are clear when a finished orbital returns to idle
   a_grad_clear: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == S_WRITE && state_ff == S_IDLE) |->
         (grad_x_ff == '0 && grad_y_ff == '0 && grad_z_ff == '0))
      else $error("gradient sums not cleared after an orbital");

   // a new result only comes from write-back
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_WRITE))
      else $error("result raised outside write-back");

   // reduced point and store address stay in range at write-back
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |->
         (32'(r_ff) < 32'(GRID_POINTS) && 32'(addr_ff) < 32'(STORE_DEPTH)))
      else $error("density store address out of range");

   // no new beat is taken while squares are being built
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (mul_valid_ff || state_ff == S_SQ) |-> !req_tready)
      else $error("beat accepted while the square sequence runs");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int POINT_W    = oked_pkg::POINT_W;
   localparam int VAL_W      = oked_pkg::VAL_W;
   localparam int GRAD_W     = oked_pkg::GRAD_W;
   localparam int DENS_W     = oked_pkg::DENS_W;
   localparam int ACC_W      = oked_pkg::ACC_W;
   localparam int REQ_DATA_W = oked_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = oked_pkg::RSP_DATA_W;

   localparam int GRID = oked_pkg::GRID_POINTS_DEF;
   localparam int TAU_SHIFT = 2 * oked_pkg::FRAC_BITS_DEF;
   localparam logic [DENS_W-1:0] DENS_FULL = '1;
   localparam longint GRAD_TOP = (longint'(1) <<< (GRAD_W - 1)) - 1;
   localparam longint GRAD_BOT = -GRAD_TOP - 1;
   localparam bit UNRESTRICTED = 1'b0;
   localparam bit RESTRICTED = 1'b1;
   localparam int GAP_PCT = 11;
   localparam int SETTLE_CYCLES = 24;
   localparam int DRAIN_LIMIT = 4000;

   typedef enum int {VALS_FULL, VALS_SMALL, VALS_EXTREME} value_style_type;

   typedef struct {
      logic [POINT_W-1:0]      point;
      logic                    spin;
      logic signed [VAL_W-1:0] coeff;
      logic signed [VAL_W-1:0] dx;
      logic signed [VAL_W-1:0] dy;
      logic signed [VAL_W-1:0] dz;
      logic                    is_last;
      logic                    is_first;
   } basis_beat_type;

   typedef struct {
      logic [POINT_W-1:0] point;
      logic               spin;
      logic [DENS_W-1:0]  density;
   } density_beat_type;

   // Tracks gradient sums and the density store, queues the expected updates
   class tau_ledger_type;
      bit                restricted;
      longint            gx;
      longint            gy;
      longint            gz;
      logic [DENS_W-1:0] tau_mem [0:2*GRID-1];
      density_beat_type  due_updates[$];
      int                fail_count;

      function new();
         restricted = RESTRICTED;
         gx = 0;
         gy = 0;
         gz = 0;
         fail_count = 0;
      endfunction

      function void set_mode(bit mode);
         restricted = mode;
      endfunction

      function int outstanding();
         return due_updates.size();
      endfunction

      function longint clamp_grad(longint v);
         if (v > GRAD_TOP) return GRAD_TOP;
         if (v < GRAD_BOT) return GRAD_BOT;
         return v;
      endfunction

      function logic [ACC_W-1:0] square_mag(longint g);
         logic [ACC_W-1:0] m;
         m = (g < 0) ? -g : g;
         return m * m;
      endfunction

      function void note_basis(basis_beat_type b);
         longint            c;
         logic [ACC_W-1:0]  acc;
         logic [ACC_W-1:0]  shifted;
         logic [DENS_W-1:0] contrib;
         logic [DENS_W-1:0] old;
         logic [DENS_W:0]   total;
         int                pt;
         int                idx;
         density_beat_type  e;
         c = longint'($signed(b.coeff));
         gx = clamp_grad(gx + c * longint'($signed(b.dx)));
         gy = clamp_grad(gy + c * longint'($signed(b.dy)));
         gz = clamp_grad(gz + c * longint'($signed(b.dz)));
         if (!b.is_last) return;
         // square the gradient exactly, then one truncating shift
         acc = square_mag(gx) + square_mag(gy) + square_mag(gz);
         if (restricted) acc = acc << 1;
         shifted = acc >> TAU_SHIFT;
         contrib = (shifted > DENS_FULL) ? DENS_FULL : shifted[DENS_W-1:0];
         pt = int'(b.point) % GRID;
         idx = int'(b.spin) * GRID + pt;
         old = b.is_first ? '0 : tau_mem[idx];
         total = {1'b0, old} + {1'b0, contrib};
         tau_mem[idx] = total[DENS_W] ? DENS_FULL : total[DENS_W-1:0];
         gx = 0;
         gy = 0;
         gz = 0;
         e.point = POINT_W'(pt);
         e.spin = b.spin;
         e.density = tau_mem[idx];
         due_updates.push_back(e);
      endfunction

      function void check_update(logic [POINT_W-1:0] point, logic spin,
                                 logic [DENS_W-1:0] density);
         density_beat_type e;
         if (due_updates.size() == 0) begin
            $display("%0t: unexpected density beat point %0d spin %0d density %h",
                     $time, point, spin, density);
            fail_count++;
            return;
         end
         e = due_updates.pop_front();
         if (point !== e.point) begin
            $display("%0t: point mismatch: expected %0d, actual %0d",
                     $time, e.point, point);
            fail_count++;
         end
         if (spin !== e.spin) begin
            $display("%0t: spin mismatch: expected %0d, actual %0d",
                     $time, e.spin, spin);
            fail_count++;
         end
         if (density !== e.density) begin
            $display("%0t: density mismatch: expected %h, actual %h",
                     $time, e.density, density);
            fail_count++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic                  csr_data;

   tau_ledger_type ledger = new();
   bit        seeded [0:2*GRID-1];
   int        live_entries[$];
   int        beats_sent = 0;
   bit        req_calm = 1'b0;
   bit        rsp_calm = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   orbital_kinetic_energy_density i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Stall the result side at random unless in a calm stretch
   always @(negedge clock) begin
      rsp_tready <= rsp_calm || ($urandom_range(99) >= GAP_PCT);
   end

   // Check each accepted result beat
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         ledger.check_update(rsp_tdata[POINT_W-1:0], rsp_tdata[POINT_W],
                             rsp_tdata[POINT_W+DENS_W:POINT_W+1]);
      end
   end

   function automatic logic signed [VAL_W-1:0] pick_value(value_style_type style);
      unique case (style)
         VALS_SMALL: begin
            return VAL_W'($signed($urandom_range(512)) - 256);
         end
         VALS_EXTREME: begin
            return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         end
         default: begin
            return VAL_W'($urandom_range(16'hFFFF));
         end
      endcase
   endfunction

   // Present one beat, idling at random first, and hold until accepted
   task automatic send_beat(input basis_beat_type b);
      int idx;
      @(negedge clock);
      while (!req_calm && $urandom_range(99) < GAP_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, b.dz, b.dy, b.dx, b.coeff, b.spin, b.point};
      req_tlast <= b.is_last;
      req_tuser <= b.is_first;
      do @(posedge clock); while (!req_tready);
      ledger.note_basis(b);
      beats_sent++;
      // remember written entries so adds only land on them
      if (b.is_last) begin
         idx = int'(b.spin) * GRID + int'(b.point) % GRID;
         seeded[idx] = 1'b1;
         live_entries.push_back(idx);
         if (live_entries.size() > 12) void'(live_entries.pop_front());
      end
   endtask

   task automatic send_single(input int point, input int spin, input int coeff,
                              input int dx, input int dy, input int dz,
                              input int last_beat, input int first_orb);
      basis_beat_type b;
      b.point = POINT_W'(point);
      b.spin = 1'(spin);
      b.coeff = VAL_W'(coeff);
      b.dx = VAL_W'(dx);
      b.dy = VAL_W'(dy);
      b.dz = VAL_W'(dz);
      b.is_last = 1'(last_beat);
      b.is_first = 1'(first_orb);
      send_beat(b);
   endtask

   // Stream one orbital; steady holds extreme values to drive saturation
   task automatic send_orbital(input logic [POINT_W-1:0] point, input logic spin,
                               input logic first_orb, input int n,
                               input value_style_type style, input bit steady);
      basis_beat_type          b;
      logic signed [VAL_W-1:0] c0;
      logic signed [VAL_W-1:0] x0;
      logic signed [VAL_W-1:0] y0;
      logic signed [VAL_W-1:0] z0;
      c0 = pick_value(VALS_EXTREME);
      x0 = pick_value(VALS_EXTREME);
      y0 = pick_value(VALS_EXTREME);
      z0 = pick_value(VALS_EXTREME);
      for (int i = 0; i < n; i++) begin
         b.point = POINT_W'($urandom_range(GRID - 1));
         b.spin = 1'($urandom_range(1));
         b.is_first = 1'($urandom_range(1));
         b.is_last = 1'b0;
         if (steady) begin
            b.coeff = c0;
            b.dx = x0;
            b.dy = y0;
            b.dz = ($urandom_range(9) == 0) ? pick_value(VALS_FULL) : z0;
         end else begin
            b.coeff = pick_value(style);
            b.dx = pick_value(style);
            b.dy = pick_value(style);
            b.dz = pick_value(style);
         end
         if (i == n - 1) begin
            b.point = point;
            b.spin = spin;
            b.is_first = first_orb;
            b.is_last = 1'b1;
         end
         send_beat(b);
      end
   endtask

   // Pick a target entry: reuse a recent one or pick one at random, overwriting it if never written
   task automatic pick_entry(output logic [POINT_W-1:0] point, output logic spin,
                             output logic first_orb);
      int idx;
      if (live_entries.size() > 0 && $urandom_range(99) < 60) begin
         idx = live_entries[$urandom_range(live_entries.size() - 1)];
         first_orb = ($urandom_range(99) < 15);
      end else begin
         idx = $urandom_range(2 * GRID - 1);
         first_orb = seeded[idx] ? 1'($urandom_range(1)) : 1'b1;
      end
      point = POINT_W'(idx % GRID);
      spin = 1'(idx / GRID);
   endtask

   task automatic run_random(input int target);
      int                 start;
      int                 r;
      logic [POINT_W-1:0] p;
      logic               s;
      logic               f;
      value_style_type    style;
      start = beats_sent;
      while (beats_sent - start < target) begin
         pick_entry(p, s, f);
         r = $urandom_range(99);
         style = ($urandom_range(99) < 30) ? VALS_SMALL : VALS_FULL;
         if (r < 4) send_orbital(p, s, f, $urandom_range(80, 66), VALS_EXTREME, 1'b1);
         else if (r < 16) send_orbital(p, s, f, $urandom_range(32, 9), style, 1'b0);
         else if (r < 56) send_orbital(p, s, f, $urandom_range(4, 1), style, 1'b0);
         else send_orbital(p, s, f, $urandom_range(8, 5), style, 1'b0);
      end
   endtask

   // Drop valid, drain all results, then let the write-back finish
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (ledger.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input bit mode);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= mode;
      do @(posedge clock); while (!csr_ready);
      ledger.set_mode(mode);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // restricted mode as it comes out of reset
      send_single(0, 0, 0, 0, 0, 0, 1, 1);
      send_single(4095, 1, -32768, -32768, 32767, -32768, 1, 1);
      send_single(4095, 1, 32767, 32767, -32768, 1, 1, 0);
      // point, spin and flag of a non-closing beat are ignored
      send_single(123, 1, 1, 5, -7, 3, 0, 0);
      send_single(0, 0, -1, 5, -7, 3, 1, 0);
      // contribution below one LSB truncates to nothing
      send_single(0, 0, 1, 1, 1, 1, 1, 0);
      send_single(2730, 1, 4096, 4096, -4096, 4096, 0, 1);
      send_single(1365, 0, 4096, -4096, 4096, 4096, 0, 0);
      send_single(2048, 0, 4096, 4096, 4096, -4096, 1, 1);
      // overwrite an entry that already holds a value
      send_single(4095, 1, 16, 16, 16, 16, 1, 1);
      settle();

      write_mode(UNRESTRICTED);
      send_single(4095, 1, -32768, -32768, -32768, -32768, 1, 0);
      send_single(2048, 0, 3, -1, 1, -1, 1, 0);
      send_single(1, 0, 1, 1, 0, 0, 1, 1);
      send_single(1, 0, 1, 1, 0, 0, 1, 0);
      settle();

      // long run that pins the x and y gradient sums at their limits
      write_mode(RESTRICTED);
      send_orbital(12'd3000, 1'b0, 1'b1, 520, VALS_FULL, 1'b1);
      run_random(170);
      settle();

      // calm stretch: no idling on either side
      write_mode(UNRESTRICTED);
      req_calm = 1'b1;
      rsp_calm = 1'b1;
      run_random(170);
      settle();
      req_calm = 1'b0;
      rsp_calm = 1'b0;

      write_mode(RESTRICTED);
      run_random(170);
      settle();

      write_mode(UNRESTRICTED);
      run_random(170);

      // drain with a bound, then flag anything still owed
      @(negedge clock);
      req_tvalid <= 1'b0;
      for (int i = 0; i < DRAIN_LIMIT && ledger.outstanding() != 0; i++) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ledger.outstanding() != 0) begin
         $display("%0t: %0d density updates never arrived", $time, ledger.outstanding());
         ledger.fail_count++;
      end
      if (ledger.fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #400000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/oked_pkg.sv
rtl/orbital_kinetic_energy_density.sv
dv/tb.sv
